FILE: hdl/rv32ie_pkg.sv
// rv32ie_pkg: opcodes, function codes and shared structs for the RV32I execute block.
// No dependencies; imported by every module under hdl/.
package rv32ie_pkg;

    localparam int XLEN = 32;
    localparam int RIDX_W = 5;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;

    // funct3 codes, branch group
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct3 codes, ALU groups
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_JALR = 3'd0;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    // Status codes
    localparam logic STS_OK          = 1'b0;
    localparam logic STS_UNSUPPORTED = 1'b1;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_write;

    // Execute result of one instruction
    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              reg_write;
        logic [RIDX_W-1:0] dest_reg;
        logic [XLEN-1:0]   write_value;
        logic              status;
    } t_exec_result;

endpackage

FILE: hdl/rv32ie_regfile.sv
// rv32ie_regfile: register file in a synchronous RAM with registered reads, two read ports.
// Per-entry valid bits give the reset-to-zero view; last write is forwarded. Uses rv32ie_pkg.
module rv32ie_regfile
    import rv32ie_pkg::*;
#(
    parameter int NUM_REGS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [RIDX_W-1:0] i_rs1_addr,
    input  logic [RIDX_W-1:0] i_rs2_addr,
    input  t_rf_write         i_wr,
    output logic [XLEN-1:0]   o_rs1_data,
    output logic [XLEN-1:0]   o_rs2_data
);

    localparam int AW = $clog2(NUM_REGS);
    localparam logic [RIDX_W:0] NREG = (RIDX_W + 1)'(NUM_REGS);

    logic [XLEN-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;

    logic [XLEN-1:0]   r_rs1_q;
    logic [XLEN-1:0]   r_rs2_q;
    logic              r_rs1_live;
    logic              r_rs2_live;
    logic [RIDX_W-1:0] r_rs1_idx;
    logic [RIDX_W-1:0] r_rs2_idx;

    logic              r_fwd_en;
    logic [RIDX_W-1:0] r_fwd_addr;
    logic [XLEN-1:0]   r_fwd_data;

    logic rs1_in_range;
    logic rs2_in_range;

    assign rs1_in_range = ({1'b0, i_rs1_addr} < NREG);
    assign rs2_in_range = ({1'b0, i_rs2_addr} < NREG);

    // RAM: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rs1_q   <= mem[i_rs1_addr[AW-1:0]];
            r_rs2_q   <= mem[i_rs2_addr[AW-1:0]];
            r_rs1_idx <= i_rs1_addr;
            r_rs2_idx <= i_rs2_addr;
        end
        if (i_wr.en) begin
            r_fwd_addr <= i_wr.addr;
            r_fwd_data <= i_wr.data;
        end
    end

    // Valid bits: entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rs1_live <= 1'b0;
            r_rs2_live <= 1'b0;
            r_fwd_en   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr[AW-1:0]] <= 1'b1;
                r_fwd_en                   <= 1'b1;
            end
            if (i_rd_en) begin
                r_rs1_live <= rs1_in_range && r_valid[i_rs1_addr[AW-1:0]];
                r_rs2_live <= rs2_in_range && r_valid[i_rs2_addr[AW-1:0]];
            end
        end
    end

    // Write landing on the same edge as the read is not in r_rs*_q yet
    always_comb begin
        if (r_fwd_en && r_fwd_addr == r_rs1_idx) begin
            o_rs1_data = r_fwd_data;
        end else if (r_rs1_live) begin
            o_rs1_data = r_rs1_q;
        end else begin
            o_rs1_data = '0;
        end
        if (r_fwd_en && r_fwd_addr == r_rs2_idx) begin
            o_rs2_data = r_fwd_data;
        end else if (r_rs2_live) begin
            o_rs2_data = r_rs2_q;
        end else begin
            o_rs2_data = '0;
        end
    end

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> i_wr.addr != '0)
        else $error("write to x0");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> {1'b0, i_wr.addr} < NREG)
        else $error("write beyond register count");

    a_fwd_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> r_fwd_en && r_fwd_data == $past(i_wr.data))
        else $error("forward register missed a write");

endmodule

FILE: hdl/rv32ie_alu.sv
// rv32ie_alu: decode and execute of one RV32I integer instruction, purely combinational.
// Produces next PC, writeback and status. Uses rv32ie_pkg.
module rv32ie_alu
    import rv32ie_pkg::*;
#(
    parameter int NUM_REGS = 32
) (
    input  logic [XLEN-1:0] i_instr,
    input  logic [XLEN-1:0] i_pc,
    input  logic [XLEN-1:0] i_a,
    input  logic [XLEN-1:0] i_b,
    output t_exec_result    o_res
);

    localparam logic [RIDX_W:0] NREG = (RIDX_W + 1)'(NUM_REGS);

    logic [6:0]        opc;
    logic [RIDX_W-1:0] rd;
    logic [2:0]        f3;
    logic [RIDX_W-1:0] rs1;
    logic [RIDX_W-1:0] rs2;
    logic [6:0]        f7;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_u;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   pc4;
    logic [XLEN-1:0]   npc;
    logic [XLEN-1:0]   val;
    logic              ok;
    logic              wr;
    logic              use_rd;
    logic              use_rs1;
    logic              use_rs2;
    logic              take;
    logic              range_bad;
    logic [4:0]        shamt_r;

    assign opc   = i_instr[6:0];
    assign rd    = i_instr[11:7];
    assign f3    = i_instr[14:12];
    assign rs1   = i_instr[19:15];
    assign rs2   = i_instr[24:20];
    assign f7    = i_instr[31:25];
    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_u = {i_instr[31:12], 12'h000};
    assign imm_b = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign imm_j = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};
    assign pc4     = i_pc + PC_STEP;
    assign shamt_r = i_b[4:0];

    always_comb begin
        npc     = pc4;
        val     = '0;
        ok      = 1'b1;
        wr      = 1'b0;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        take    = 1'b0;
        case (opc)
            OPC_LUI: begin
                wr = 1'b1; use_rd = 1'b1; val = imm_u;
            end
            OPC_AUIPC: begin
                wr = 1'b1; use_rd = 1'b1; val = i_pc + imm_u;
            end
            OPC_JAL: begin
                wr = 1'b1; use_rd = 1'b1; val = pc4; npc = i_pc + imm_j;
            end
            OPC_JALR: begin
                if (f3 != F3_JALR) begin
                    ok = 1'b0;
                end else begin
                    wr = 1'b1; use_rd = 1'b1; use_rs1 = 1'b1; val = pc4;
                    npc = (i_a + imm_i) & ~32'd1;
                end
            end
            OPC_BRANCH: begin
                use_rs1 = 1'b1; use_rs2 = 1'b1;
                case (f3)
                    F3_BEQ:  take = (i_a == i_b);
                    F3_BNE:  take = (i_a != i_b);
                    F3_BLT:  take = ($signed(i_a) < $signed(i_b));
                    F3_BGE:  take = !($signed(i_a) < $signed(i_b));
                    F3_BLTU: take = (i_a < i_b);
                    F3_BGEU: take = !(i_a < i_b);
                    default: ok = 1'b0;
                endcase
                if (ok && take) begin
                    npc = i_pc + imm_b;
                end
            end
            OPC_OP_IMM: begin
                wr = 1'b1; use_rd = 1'b1; use_rs1 = 1'b1;
                case (f3)
                    F3_ADD:  val = i_a + imm_i;
                    F3_SLT:  val = {31'd0, $signed(i_a) < $signed(imm_i)};
                    F3_SLTU: val = {31'd0, i_a < imm_i};
                    F3_XOR:  val = i_a ^ imm_i;
                    F3_OR:   val = i_a | imm_i;
                    F3_AND:  val = i_a & imm_i;
                    F3_SLL: begin
                        if (f7 != F7_BASE) ok = 1'b0;
                        else val = i_a << rs2;
                    end
                    default: begin
                        if (f7 == F7_BASE) val = i_a >> rs2;
                        else if (f7 == F7_ALT) val = XLEN'($signed(i_a) >>> rs2);
                        else ok = 1'b0;
                    end
                endcase
            end
            OPC_OP: begin
                wr = 1'b1; use_rd = 1'b1; use_rs1 = 1'b1; use_rs2 = 1'b1;
                if ((f7 == F7_ALT && f3 != F3_ADD && f3 != F3_SR) ||
                    (f7 != F7_BASE && f7 != F7_ALT)) begin
                    ok = 1'b0;
                end else begin
                    case (f3)
                        F3_ADD:  val = (f7 == F7_BASE) ? i_a + i_b : i_a - i_b;
                        F3_SLL:  val = i_a << shamt_r;
                        F3_SLT:  val = {31'd0, $signed(i_a) < $signed(i_b)};
                        F3_SLTU: val = {31'd0, i_a < i_b};
                        F3_XOR:  val = i_a ^ i_b;
                        F3_SR:   val = (f7 == F7_BASE) ? i_a >> shamt_r
                                                       : XLEN'($signed(i_a) >>> shamt_r);
                        F3_OR:   val = i_a | i_b;
                        default: val = i_a & i_b;
                    endcase
                end
            end
            default: ok = 1'b0;
        endcase
    end

    assign range_bad = (use_rd  && {1'b0, rd}  >= NREG) ||
                       (use_rs1 && {1'b0, rs1} >= NREG) ||
                       (use_rs2 && {1'b0, rs2} >= NREG);

    always_comb begin
        o_res = '0;
        if (ok && !range_bad) begin
            o_res.next_pc = npc;
            o_res.status  = STS_OK;
            if (wr && rd != '0) begin
                o_res.reg_write   = 1'b1;
                o_res.dest_reg    = rd;
                o_res.write_value = val;
            end
        end else begin
            o_res.next_pc = pc4;
            o_res.status  = STS_UNSUPPORTED;
        end
    end

endmodule

FILE: hdl/rv32i_integer_execute.sv
// rv32i_integer_execute: top level of the RV32I integer execute block.
// Depends on rv32ie_pkg, rv32ie_regfile and rv32ie_alu.
//
// Executes one RV32I integer instruction per transaction (LUI, AUIPC, JAL, JALR, branches,
// OP-IMM, OP) against an internal register file and program counter, both zero after reset.
// The instruction is assumed fetched at the current PC; each result transaction carries the
// next PC, the writeback (register, value), a status (1 = unsupported, only PC advances by 4)
// and done_res (next PC at or above program_end). Timing: an accepted instruction has its
// operands read from the register file RAM at the accept edge, is executed in the following
// cycle, then lands in the output register at the execute-stage advance. Without stalls,
// throughput is one instruction per cycle. Back-to-back dependencies need no stall: the write
// of the previous instruction lands on the same edge as the next read and is forwarded from a
// bypass register. The PC update and the result share the execute-stage advance, so a stalled
// output holds the execute stage and then the input. No clearing pass after reset: a valid
// bit per register makes unwritten entries read as zero at once. program_end is written
// through i_cfg_we/i_cfg_wdata and should only change while no transaction is in flight.
module rv32i_integer_execute
    import rv32ie_pkg::*;
#(
    parameter int NUM_REGS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config
    input  logic              i_cfg_we,
    input  logic [XLEN-1:0]   i_cfg_wdata,
    // instruction channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [XLEN-1:0]   i_instruction,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [XLEN-1:0]   o_next_pc,
    output logic              o_reg_write,
    output logic [RIDX_W-1:0] o_dest_reg,
    output logic [XLEN-1:0]   o_write_value,
    output logic              o_status,
    output logic              o_done_res
);

    logic [XLEN-1:0] r_program_end;
    logic [XLEN-1:0] r_pc;

    // execute stage
    logic            r_e_valid;
    logic [XLEN-1:0] r_e_instr;

    logic            in_accept;
    logic            e_advance;
    logic            e_fire;
    logic [XLEN-1:0] rs1_data;
    logic [XLEN-1:0] rs2_data;
    t_exec_result    ex_res;
    t_rf_write       rf_wr;

    // output register frees when empty or being taken
    assign e_advance  = !o_out_valid || i_out_ready;
    assign e_fire     = r_e_valid && e_advance;
    assign o_in_ready = !r_e_valid || e_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    rv32ie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rs1_addr (i_instruction[19:15]),
        .i_rs2_addr (i_instruction[24:20]),
        .i_wr       (rf_wr),
        .o_rs1_data (rs1_data),
        .o_rs2_data (rs2_data)
    );

    rv32ie_alu #(
        .NUM_REGS (NUM_REGS)
    ) u_alu (
        .i_instr (r_e_instr),
        .i_pc    (r_pc),
        .i_a     (rs1_data),
        .i_b     (rs2_data),
        .o_res   (ex_res)
    );

    // writeback commits with the execute-stage advance
    always_comb begin
        rf_wr.en   = e_fire && ex_res.reg_write;
        rf_wr.addr = ex_res.dest_reg;
        rf_wr.data = ex_res.write_value;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_program_end <= '0;
            r_pc          <= '0;
            r_e_valid     <= 1'b0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_program_end <= i_cfg_wdata;
            end
            if (e_fire) begin
                r_pc <= ex_res.next_pc;
            end
            if (o_in_ready) begin
                r_e_valid <= i_in_valid;
            end
            if (e_advance) begin
                o_out_valid <= r_e_valid;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_e_instr <= i_instruction;
        end
        if (e_fire) begin
            o_next_pc     <= ex_res.next_pc;
            o_reg_write   <= ex_res.reg_write;
            o_dest_reg    <= ex_res.dest_reg;
            o_write_value <= ex_res.write_value;
            o_status      <= ex_res.status;
            o_done_res    <= (ex_res.next_pc >= r_program_end);
        end
    end

    a_pc_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_fire |=> o_out_valid && r_pc == o_next_pc)
        else $error("PC and reported next_pc diverged");

    a_unsupported_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STS_UNSUPPORTED |-> !o_reg_write)
        else $error("unsupported instruction wrote a register");

    a_no_write_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reg_write |-> o_dest_reg == '0 && o_write_value == '0)
        else $error("writeback fields set without reg_write");

    a_stall_holds_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid && !e_advance |=> r_e_valid && $stable(r_e_instr) && $stable(r_pc))
        else $error("execute stage changed while stalled");

endmodule
